>>> sv/ems_pkg.sv
// ----------------------------------------------------------------------------
// Move sequencer package
// Shared types, codes and constants of the two-wheel move sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ems_pkg;

   // Default number of queue slots; the queue holds one entry fewer.
   localparam int QUEUE_DEPTH_DEF = 20;

   // Encoder sample and detection threshold width.
   localparam int SAMPLE_BITS = 10;
   // Pulse count and idle tick widths.
   localparam int COUNT_BITS = 8;
   localparam int IDLE_BITS = 16;
   // Configuration port widths.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // Configuration register reset values.
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(300);
   localparam logic [COUNT_BITS-1:0] STRAIGHT_RST = COUNT_BITS'(37);
   localparam logic [COUNT_BITS-1:0] TURN_RST = COUNT_BITS'(23);
   localparam logic [IDLE_BITS-1:0] TIMEOUT_RST = IDLE_BITS'(1500);

   // Request kinds.
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_PUSH  = 2'd1,
      REQ_START = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   // Queued move codes.
   typedef enum logic [1:0] {
      MOVE_FORWARD = 2'd0,
      MOVE_BACK    = 2'd1,
      MOVE_RIGHT   = 2'd2,
      MOVE_LEFT    = 2'd3
   } move_code_type;

   // Bridge drive levels.
   typedef enum logic [1:0] {
      DRV_OFF = 2'd0,
      DRV_FWD = 2'd1,
      DRV_REV = 2'd2
   } drive_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_BUSY      = 3'd3,
      ST_MOVE_DONE = 3'd4,
      ST_SEQ_DONE  = 3'd5,
      ST_TIMEOUT   = 3'd6
   } status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_THRESHOLD      = 3'd0,
      REG_STRAIGHT_RIGHT = 3'd1,
      REG_STRAIGHT_LEFT  = 3'd2,
      REG_TURN_RIGHT     = 3'd3,
      REG_TURN_LEFT      = 3'd4,
      REG_TIMEOUT        = 3'd5
   } csr_reg_type;

   // Input item.
   typedef struct packed {
      req_kind_type             req_type;
      move_code_type            command_code;
      logic [SAMPLE_BITS-1:0]   right_sample;
      logic [SAMPLE_BITS-1:0]   left_sample;
   } req_payload_type;

   // Result item.
   typedef struct packed {
      logic                     right_enable;
      drive_type                right_drive;
      logic                     left_enable;
      drive_type                left_drive;
      logic                     moving;
      logic                     queue_running;
      status_type               status;
      logic [COUNT_BITS-1:0]    right_count;
      logic [COUNT_BITS-1:0]    left_count;
   } rsp_payload_type;

   // Per-wheel pulse tracking state.
   typedef struct packed {
      logic                     latch;
      logic [COUNT_BITS-1:0]    count;
      logic [IDLE_BITS-1:0]     idle;
   } wheel_state_type;

   // Per-wheel end-of-move flags.
   typedef struct packed {
      logic                     done;
      logic                     expired;
   } wheel_flags_type;

endpackage

`default_nettype wire

>>> sv/ems_wheel.sv
// ----------------------------------------------------------------------------
// Move sequencer wheel tracker
// Pulse detection, saturating count, idle ticks and done/expired flags of
// one wheel for one sample tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ems_wheel
   import ems_pkg::*;
(
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [SAMPLE_BITS-1:0] prev_sample,
   input  wire logic [SAMPLE_BITS-1:0] threshold,
   input  wire logic [COUNT_BITS-1:0]  target,
   input  wire logic [IDLE_BITS-1:0]   timeout,
   input  wire wheel_state_type        base,
   output wheel_state_type             next,
   output wheel_flags_type             flags
);

   logic [SAMPLE_BITS-1:0] diff;
   logic                   jump;
   logic                   pulsed;

   // Absolute sample difference against the previous tick.
   assign diff = (sample >= prev_sample) ? (sample - prev_sample) : (prev_sample - sample);
   assign jump = diff > threshold;
   // A pulse counts once per jump; the latch holds until the jump falls back.
   assign pulsed = jump && !base.latch;

   always_comb begin
      next.latch = jump;
      next.count = base.count;
      if (pulsed && (base.count != {COUNT_BITS{1'b1}})) begin
         next.count = base.count + 1'b1;
      end
      // Idle ticks restart on a pulse and otherwise count up, saturating.
      if (pulsed) begin
         next.idle = '0;
      end else if (base.idle != {IDLE_BITS{1'b1}}) begin
         next.idle = base.idle + 1'b1;
      end else begin
         next.idle = base.idle;
      end
      flags.done = next.count >= target;
      flags.expired = (next.count != '0) && (next.idle >= timeout);
   end

endmodule

`default_nettype wire

>>> sv/encoder_move_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Encoder move sequencer
// Queues forward, back and turn moves and plays them on two wheels, counting
// encoder pulses against per-move targets, with an idle timeout.
// ----------------------------------------------------------------------------
// Every accepted request produces exactly one result. The block takes one
// request per clock while results are taken; each request passes through the
// input register, then a single pass of queue, pulse and status logic into the
// result register. A held result stalls a full input register, though a request
// can still enter it while it is empty. The move queue holds QUEUE_DEPTH - 1
// entries; pushes beyond that report a full queue. Configuration writes are
// taken at any cycle and are meant to happen while no request is in flight.
`default_nettype none

module encoder_move_sequencer_unit
   import ems_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire req_payload_type           req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_payload_type                rsp_payload,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_BITS-1:0] LEN_MAX = IDX_BITS'(QUEUE_DEPTH - 1);

   // Configuration registers.
   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [COUNT_BITS-1:0]  straight_right_ff;
   logic [COUNT_BITS-1:0]  straight_left_ff;
   logic [COUNT_BITS-1:0]  turn_right_ff;
   logic [COUNT_BITS-1:0]  turn_left_ff;
   logic [IDLE_BITS-1:0]   timeout_ff;

   // Input and result registers.
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   logic            step;

   // Sequencer state.
   move_code_type          queue_ff [QUEUE_DEPTH];
   logic [IDX_BITS-1:0]    len_ff;
   logic [IDX_BITS-1:0]    len_in;
   logic [IDX_BITS-1:0]    idx_ff;
   logic [IDX_BITS-1:0]    idx_in;
   logic                   playing_ff;
   logic                   playing_in;
   logic                   motion_ff;
   logic                   motion_in;
   logic [COUNT_BITS-1:0]  target_ff [2];
   logic [COUNT_BITS-1:0]  target_in [2];
   drive_type              dir_ff [2];
   drive_type              dir_in [2];
   logic                   en_ff [2];
   logic                   en_in [2];
   logic [SAMPLE_BITS-1:0] prev_ff [2];
   logic [SAMPLE_BITS-1:0] prev_in [2];
   wheel_state_type        wheel_ff [2];
   wheel_state_type        wheel_in [2];
   logic                   q_we;
   status_type             status;

   // Decode of the current request.
   logic                   is_tick;
   logic                   start_ok;
   logic [IDX_BITS-1:0]    adv_idx;
   logic                   avail;
   logic                   want_next;
   logic                   load;
   logic                   seq_done;
   logic                   sampling;
   move_code_type          new_code;
   logic [COUNT_BITS-1:0]  new_target [2];
   drive_type              new_dir [2];
   logic [COUNT_BITS-1:0]  use_target [2];
   logic [SAMPLE_BITS-1:0] tick_sample [2];
   wheel_state_type        wheel_base [2];
   wheel_state_type        wheel_next [2];
   wheel_flags_type        wheel_flags [2];

   // Handshake: the input register moves on whenever the result register can
   // take a new result.
   assign step = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
         straight_right_ff <= STRAIGHT_RST;
         straight_left_ff <= STRAIGHT_RST;
         turn_right_ff <= TURN_RST;
         turn_left_ff <= TURN_RST;
         timeout_ff <= TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD:      threshold_ff <= csr_wdata[SAMPLE_BITS-1:0];
            REG_STRAIGHT_RIGHT: straight_right_ff <= csr_wdata[COUNT_BITS-1:0];
            REG_STRAIGHT_LEFT:  straight_left_ff <= csr_wdata[COUNT_BITS-1:0];
            REG_TURN_RIGHT:     turn_right_ff <= csr_wdata[COUNT_BITS-1:0];
            REG_TURN_LEFT:      turn_left_ff <= csr_wdata[COUNT_BITS-1:0];
            REG_TIMEOUT:        timeout_ff <= csr_wdata[IDLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Decide whether this request loads a move and what the wheels start from.
   always_comb begin
      is_tick = in_data_ff.req_type == REQ_TICK;
      start_ok = (in_data_ff.req_type == REQ_START) && (len_ff != '0) && !playing_ff;
      adv_idx = start_ok ? '0 : idx_ff;
      avail = adv_idx < len_ff;
      want_next = is_tick && playing_ff && !motion_ff;
      load = start_ok || (want_next && avail);
      seq_done = want_next && !avail;
      sampling = is_tick && (motion_ff || load);
      new_code = queue_ff[adv_idx];
      if ((new_code == MOVE_FORWARD) || (new_code == MOVE_BACK)) begin
         new_target[0] = straight_right_ff;
         new_target[1] = straight_left_ff;
      end else begin
         new_target[0] = turn_right_ff;
         new_target[1] = turn_left_ff;
      end
      unique case (new_code)
         MOVE_FORWARD: begin
            new_dir[0] = DRV_FWD;
            new_dir[1] = DRV_FWD;
         end
         MOVE_BACK: begin
            new_dir[0] = DRV_REV;
            new_dir[1] = DRV_REV;
         end
         MOVE_RIGHT: begin
            new_dir[0] = DRV_REV;
            new_dir[1] = DRV_FWD;
         end
         MOVE_LEFT: begin
            new_dir[0] = DRV_FWD;
            new_dir[1] = DRV_REV;
         end
      endcase
      tick_sample[0] = in_data_ff.right_sample;
      tick_sample[1] = in_data_ff.left_sample;
      for (int w = 0; w < 2; w++) begin
         use_target[w] = load ? new_target[w] : target_ff[w];
         wheel_base[w].latch = wheel_ff[w].latch;
         wheel_base[w].count = load ? '0 : wheel_ff[w].count;
         wheel_base[w].idle = load ? '0 : wheel_ff[w].idle;
      end
   end

   // Per-wheel pulse tracking.
   ems_wheel u_wheel_right (
      .sample      (tick_sample[0]),
      .prev_sample (prev_ff[0]),
      .threshold   (threshold_ff),
      .target      (use_target[0]),
      .timeout     (timeout_ff),
      .base        (wheel_base[0]),
      .next        (wheel_next[0]),
      .flags       (wheel_flags[0])
   );

   ems_wheel u_wheel_left (
      .sample      (tick_sample[1]),
      .prev_sample (prev_ff[1]),
      .threshold   (threshold_ff),
      .target      (use_target[1]),
      .timeout     (timeout_ff),
      .base        (wheel_base[1]),
      .next        (wheel_next[1]),
      .flags       (wheel_flags[1])
   );

   // Next sequencer state and the result of this request.
   always_comb begin
      len_in = len_ff;
      idx_in = idx_ff;
      playing_in = playing_ff;
      motion_in = motion_ff;
      target_in = target_ff;
      dir_in = dir_ff;
      en_in = en_ff;
      prev_in = prev_ff;
      wheel_in = wheel_ff;
      q_we = 1'b0;
      status = ST_OK;
      if (step) begin
         // A move is loaded on an accepted start or on a tick between moves.
         if (load) begin
            playing_in = 1'b1;
            idx_in = IDX_BITS'(adv_idx + 1'b1);
            motion_in = 1'b1;
            for (int w = 0; w < 2; w++) begin
               target_in[w] = new_target[w];
               dir_in[w] = new_dir[w];
               en_in[w] = 1'b1;
               wheel_in[w].count = '0;
               wheel_in[w].idle = '0;
            end
         end
         unique case (in_data_ff.req_type)
            REQ_PUSH: begin
               if (len_ff < LEN_MAX) begin
                  q_we = 1'b1;
                  len_in = len_ff + 1'b1;
               end else begin
                  status = ST_FULL;
               end
            end
            REQ_START: begin
               if (len_ff == '0) begin
                  status = ST_EMPTY;
               end else if (playing_ff) begin
                  status = ST_BUSY;
               end
            end
            REQ_CLEAR: begin
               playing_in = 1'b0;
               motion_in = 1'b0;
               len_in = '0;
               idx_in = '0;
               for (int w = 0; w < 2; w++) begin
                  en_in[w] = 1'b0;
                  dir_in[w] = DRV_OFF;
               end
            end
            REQ_TICK: begin
               if (seq_done) begin
                  playing_in = 1'b0;
                  len_in = '0;
                  status = ST_SEQ_DONE;
               end
               if (sampling) begin
                  for (int w = 0; w < 2; w++) begin
                     prev_in[w] = tick_sample[w];
                     wheel_in[w] = wheel_next[w];
                     en_in[w] = (load || en_ff[w]) && !wheel_flags[w].done;
                  end
                  // Both wheels at target ends the move.
                  if (wheel_flags[0].done && wheel_flags[1].done) begin
                     motion_in = 1'b0;
                     status = ST_MOVE_DONE;
                     for (int w = 0; w < 2; w++) begin
                        en_in[w] = 1'b0;
                        dir_in[w] = DRV_OFF;
                     end
                  end
                  // A stalled wheel aborts the move and the playback.
                  if (wheel_flags[0].expired || wheel_flags[1].expired) begin
                     motion_in = 1'b0;
                     playing_in = 1'b0;
                     status = ST_TIMEOUT;
                     for (int w = 0; w < 2; w++) begin
                        en_in[w] = 1'b0;
                        dir_in[w] = DRV_OFF;
                     end
                  end
               end
            end
         endcase
      end
      out_data_in.right_enable = en_in[0];
      out_data_in.right_drive = dir_in[0];
      out_data_in.left_enable = en_in[1];
      out_data_in.left_drive = dir_in[1];
      out_data_in.moving = motion_in;
      out_data_in.queue_running = playing_in;
      out_data_in.status = status;
      out_data_in.right_count = wheel_in[0].count;
      out_data_in.left_count = wheel_in[1].count;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         len_ff <= '0;
         idx_ff <= '0;
         playing_ff <= 1'b0;
         motion_ff <= 1'b0;
         for (int w = 0; w < 2; w++) begin
            target_ff[w] <= '0;
            dir_ff[w] <= DRV_OFF;
            en_ff[w] <= 1'b0;
            prev_ff[w] <= '0;
            wheel_ff[w] <= '0;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         len_ff <= len_in;
         idx_ff <= idx_in;
         playing_ff <= playing_in;
         motion_ff <= motion_in;
         target_ff <= target_in;
         dir_ff <= dir_in;
         en_ff <= en_in;
         prev_ff <= prev_in;
         wheel_ff <= wheel_in;
      end
   end

   // Payload registers and the move queue.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (step) begin
         out_data_ff <= out_data_in;
      end
      if (q_we) begin
         queue_ff[len_ff] <= in_data_ff.command_code;
      end
   end

endmodule

`default_nettype wire

>>> sv/ems_checker.sv
// ----------------------------------------------------------------------------
// Move sequencer port checker
// Checks result transfers for protocol and for consistent motor outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module ems_checker
   import ems_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_payload
);

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // With no move in progress both motors are stopped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.moving |->
         !rsp_payload.right_enable && !rsp_payload.left_enable &&
         rsp_payload.right_drive == DRV_OFF && rsp_payload.left_drive == DRV_OFF)
      else $error("motor driven outside a move");

   // Moves only run as part of playback.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.moving |-> rsp_payload.queue_running)
      else $error("move in progress without playback");

   // A timeout stops the move and the playback.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_TIMEOUT |->
         !rsp_payload.moving && !rsp_payload.queue_running)
      else $error("timeout left the sequencer running");

endmodule

bind encoder_move_sequencer_unit ems_checker u_ems_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
